[rtl/ums_pkg.sv]
// Shared constants and types for the 3x3 unsharp mask block.
package ums_pkg;

    localparam int PIX_W      = 8;
    localparam int IMG_W_W    = 12;
    localparam int IMG_H_W    = 13;
    localparam int AMT_W      = 12;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // blur sum reaches 16*255, diff spans -4080..4080
    localparam int BLUR_W     = 12;
    localparam int DIFF_W     = 13;
    localparam int PROD_W     = DIFF_W + AMT_W + 1;
    localparam int ACC_W      = PROD_W + 1;
    localparam int FRAC_W     = 12;
    localparam int ROUND_HALF = 2048;

    localparam logic [IMG_W_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [IMG_H_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [AMT_W-1:0]   AMOUNT_RST = 12'd256;

    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_SHARPEN_AMOUNT = 2'd2
    } t_cfg_idx;

    // which results a pixel produces
    typedef struct packed {
        logic interior;
        logic border;
    } t_emit;

endpackage

[rtl/ums_ifs.sv]
// Stream and configuration interfaces of the unsharp mask block.
interface ums_pix_if;
    logic                        valid;
    logic                        ready;
    logic [ums_pkg::PIX_W-1:0]   pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface ums_res_if #(
    parameter int ROW_W = 12,
    parameter int COL_W = 11
);
    logic                        valid;
    logic                        ready;
    logic [ums_pkg::PIX_W-1:0]   pixel_out;
    logic [ROW_W-1:0]            out_row;
    logic [COL_W-1:0]            out_column;
    logic                        last_in_run;

    modport source (output valid, output pixel_out, output out_row, output out_column,
                    output last_in_run, input ready);
    modport sink   (input valid, input pixel_out, input out_row, input out_column,
                    input last_in_run, output ready);
endinterface

interface ums_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ums_pkg::CFG_IDX_W-1:0]   index;
    logic [ums_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/ums_cfg_regs.sv]
// Configuration registers and bounded frame size.
module ums_cfg_regs #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ums_cfg_if.sink                    i_cfg,
    output logic [WW-1:0]              o_width,
    output logic [HW-1:0]              o_height,
    output logic [ums_pkg::AMT_W-1:0]  o_amount
);

    logic [ums_pkg::IMG_W_W-1:0] r_image_width;
    logic [ums_pkg::IMG_H_W-1:0] r_image_height;
    logic [ums_pkg::AMT_W-1:0]   r_sharpen_amount;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width    <= ums_pkg::WIDTH_RST;
            r_image_height   <= ums_pkg::HEIGHT_RST;
            r_sharpen_amount <= ums_pkg::AMOUNT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ums_pkg::CFG_IMAGE_WIDTH:
                    r_image_width <= i_cfg.data[ums_pkg::IMG_W_W-1:0];
                ums_pkg::CFG_IMAGE_HEIGHT:
                    r_image_height <= i_cfg.data[ums_pkg::IMG_H_W-1:0];
                ums_pkg::CFG_SHARPEN_AMOUNT:
                    r_sharpen_amount <= i_cfg.data[ums_pkg::AMT_W-1:0];
                default: ;
            endcase
        end
    end

    // zero counts as one, oversize clips to the line store size
    always_comb begin
        if (r_image_width == '0) begin
            o_width = WW'(1);
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            o_width = WW'(MAX_WIDTH);
        end else begin
            o_width = WW'(r_image_width);
        end
        if (r_image_height == '0) begin
            o_height = HW'(1);
        end else if (32'(r_image_height) > 32'(MAX_HEIGHT)) begin
            o_height = HW'(MAX_HEIGHT);
        end else begin
            o_height = HW'(r_image_height);
        end
    end

    assign o_amount = r_sharpen_amount;

endmodule

[rtl/ums_line_window.sv]
// Raster counters, line store memory, 3x3 window and binomial blur.
module ums_line_window #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic [ums_pkg::PIX_W-1:0]          i_pixel,
    input  logic [WW-1:0]                      i_width,
    input  logic [HW-1:0]                      i_height,
    output logic                               o_s1_valid,
    output logic                               o_valid,
    output logic [ums_pkg::PIX_W-1:0]          o_centre,
    output logic signed [ums_pkg::DIFF_W-1:0]  o_diff,
    output ums_pkg::t_emit                     o_emit,
    output logic [ums_pkg::PIX_W-1:0]          o_pixel,
    output logic [RW-1:0]                      o_row,
    output logic [CW-1:0]                      o_col
);

    localparam int PW = ums_pkg::PIX_W;

    // counters
    logic [CW-1:0]   r_col, n_col, x;
    logic [RW-1:0]   r_row, n_row, y;
    logic [RW:0]     y_pre, y_inc;
    logic [CW:0]     x_inc;
    ums_pkg::t_emit  emit0;

    // line store: upper half holds the row two above, lower half the row above
    logic [2*PW-1:0] mem [MAX_WIDTH];
    logic [2*PW-1:0] r_rd_data;
    logic [2*PW-1:0] r_fw_word;
    logic [2*PW-1:0] line_word;

    // stage 1
    logic            r_v1, r_fwd1;
    logic [PW-1:0]   r_pix1;
    logic [CW-1:0]   r_x1;
    logic [RW-1:0]   r_y1;
    ums_pkg::t_emit  r_emit1;

    logic [PW-1:0]   top1, mid1;
    logic [PW-1:0]   r_wc [6];
    logic [ums_pkg::BLUR_W-1:0]      blur;
    logic signed [ums_pkg::DIFF_W-1:0] diff;

    // stage 2
    logic            r_v2;
    logic [PW-1:0]   r_centre2, r_pix2;
    logic signed [ums_pkg::DIFF_W-1:0] r_diff2;
    ums_pkg::t_emit  r_emit2;
    logic [CW-1:0]   r_x2;
    logic [RW-1:0]   r_y2;

    always_comb begin
        // wrap first, in case the size shrank mid-frame
        if (32'(r_col) >= 32'(i_width)) begin
            x     = '0;
            y_pre = {1'b0, r_row} + (RW+1)'(1);
        end else begin
            x     = r_col;
            y_pre = {1'b0, r_row};
        end
        if (32'(y_pre) >= 32'(i_height)) begin
            y = '0;
        end else begin
            y = y_pre[RW-1:0];
        end

        x_inc = {1'b0, x} + (CW+1)'(1);
        y_inc = {1'b0, y} + (RW+1)'(1);
        if (32'(x_inc) >= 32'(i_width)) begin
            n_col = '0;
            n_row = (32'(y_inc) >= 32'(i_height)) ? '0 : y_inc[RW-1:0];
        end else begin
            n_col = x_inc[CW-1:0];
            n_row = y;
        end

        emit0.interior = (32'(y) >= 32'd2) && (32'(x) >= 32'd2);
        emit0.border   = (y == '0) || (x == '0)
                      || (32'(y) == 32'(i_height) - 32'd1)
                      || (32'(x) == 32'(i_width) - 32'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            if (i_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_v1 <= i_accept;
            r_v2 <= r_v1;
        end
    end

    // read at accept, write back in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd_data <= mem[x];
        end
        if (r_v1) begin
            mem[r_x1] <= {mid1, r_pix1};
        end
    end

    // a read that coincides with a write to the same column takes the new word
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pix1  <= i_pixel;
            r_x1    <= x;
            r_y1    <= y;
            r_emit1 <= emit0;
            r_fwd1  <= r_v1 && (r_x1 == x);
        end
        if (r_v1) begin
            r_fw_word <= {mid1, r_pix1};
        end
    end

    assign line_word = r_fwd1 ? r_fw_word : r_rd_data;
    assign top1      = line_word[2*PW-1:PW];
    assign mid1      = line_word[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_wc[i] <= '0;
            end
        end else if (r_v1) begin
            r_wc[0] <= r_wc[3];
            r_wc[1] <= r_wc[4];
            r_wc[2] <= r_wc[5];
            r_wc[3] <= top1;
            r_wc[4] <= mid1;
            r_wc[5] <= r_pix1;
        end
    end

    always_comb begin
        blur = ums_pkg::BLUR_W'(r_wc[0]) + ums_pkg::BLUR_W'({r_wc[3], 1'b0})
             + ums_pkg::BLUR_W'(top1)
             + ums_pkg::BLUR_W'({r_wc[1], 1'b0}) + ums_pkg::BLUR_W'({r_wc[4], 2'b00})
             + ums_pkg::BLUR_W'({mid1, 1'b0})
             + ums_pkg::BLUR_W'(r_wc[2]) + ums_pkg::BLUR_W'({r_wc[5], 1'b0})
             + ums_pkg::BLUR_W'(r_pix1);
        diff = $signed({1'b0, r_wc[4], 4'b0000}) - $signed({1'b0, blur});
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_centre2 <= r_wc[4];
            r_diff2   <= diff;
            r_emit2   <= r_emit1;
            r_pix2    <= r_pix1;
            r_x2      <= r_x1;
            r_y2      <= r_y1;
        end
    end

    assign o_s1_valid = r_v1;
    assign o_valid    = r_v2;
    assign o_centre   = r_centre2;
    assign o_diff     = r_diff2;
    assign o_emit     = r_emit2;
    assign o_pixel    = r_pix2;
    assign o_row      = r_y2;
    assign o_col      = r_x2;

endmodule

[rtl/ums_sharpen.sv]
// Gain multiply, rounding and clamp of the sharpened pixel.
module ums_sharpen #(
    parameter int ROW_W = 12,
    parameter int COL_W = 11
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [ums_pkg::PIX_W-1:0]          i_centre,
    input  logic signed [ums_pkg::DIFF_W-1:0]  i_diff,
    input  ums_pkg::t_emit                     i_emit,
    input  logic [ums_pkg::PIX_W-1:0]          i_pixel,
    input  logic [ROW_W-1:0]                   i_row,
    input  logic [COL_W-1:0]                   i_col,
    input  logic [ums_pkg::AMT_W-1:0]          i_amount,
    output logic                               o_valid,
    output logic [ums_pkg::PIX_W-1:0]          o_sharp,
    output ums_pkg::t_emit                     o_emit,
    output logic [ums_pkg::PIX_W-1:0]          o_pixel,
    output logic [ROW_W-1:0]                   o_row,
    output logic [COL_W-1:0]                   o_col
);

    localparam int AW = ums_pkg::ACC_W;
    localparam int LO = ums_pkg::FRAC_W;
    localparam int HI = ums_pkg::FRAC_W + ums_pkg::PIX_W;

    logic                                r_v3;
    logic signed [ums_pkg::PROD_W-1:0]   r_prod;
    logic [ums_pkg::PIX_W-1:0]           r_centre3, r_pix3;
    ums_pkg::t_emit                      r_emit3;
    logic [ROW_W-1:0]                    r_row3;
    logic [COL_W-1:0]                    r_col3;
    logic signed [AW-1:0]                acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_prod    <= $signed({1'b0, i_amount}) * i_diff;
            r_centre3 <= i_centre;
            r_pix3    <= i_pixel;
            r_emit3   <= i_emit;
            r_row3    <= i_row;
            r_col3    <= i_col;
        end
    end

    // value in 1/4096 units, rounded half up, then clamped to a byte
    always_comb begin
        acc = AW'(r_prod) + AW'({r_centre3, {LO{1'b0}}}) + AW'(ums_pkg::ROUND_HALF);
        if (acc[AW-1]) begin
            o_sharp = '0;
        end else if (|acc[AW-2:HI]) begin
            o_sharp = '1;
        end else begin
            o_sharp = acc[HI-1:LO];
        end
    end

    assign o_valid = r_v3;
    assign o_emit  = r_emit3;
    assign o_pixel = r_pix3;
    assign o_row   = r_row3;
    assign o_col   = r_col3;

endmodule

[rtl/ums_out_queue.sv]
// Result queue: takes up to two results a cycle, hands out one while o_res is ready.
module ums_out_queue #(
    parameter int ROW_W = 12,
    parameter int COL_W = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  ums_pkg::t_emit               i_emit,
    input  logic [ums_pkg::PIX_W-1:0]    i_sharp,
    input  logic [ums_pkg::PIX_W-1:0]    i_pixel,
    input  logic [ROW_W-1:0]             i_row,
    input  logic [COL_W-1:0]             i_col,
    output logic [ums_pkg::QCNT_W-1:0]   o_count,
    ums_res_if.source                    o_res
);

    localparam int QD = ums_pkg::QUEUE_DEPTH;
    localparam int PW = ums_pkg::QPTR_W;
    localparam int NW = ums_pkg::QCNT_W;

    logic [ums_pkg::PIX_W-1:0] q_pix [QD];
    logic [ROW_W-1:0]          q_row [QD];
    logic [COL_W-1:0]          q_col [QD];
    logic                      q_last [QD];

    logic [PW-1:0] r_wr, r_rd, wr_b;
    logic [NW-1:0] r_count;
    logic          push_a, push_b, pop;
    logic [NW-1:0] n_push;

    assign push_a = i_valid && i_emit.interior;
    assign push_b = i_valid && i_emit.border;
    assign pop    = o_res.valid && o_res.ready;
    assign n_push = NW'(push_a) + NW'(push_b);
    assign wr_b   = r_wr + PW'(push_a);

    // the interior pixel is older in raster order and goes first
    always_ff @(posedge i_clk) begin
        if (push_a) begin
            q_pix[r_wr]  <= i_sharp;
            q_row[r_wr]  <= i_row - ROW_W'(1);
            q_col[r_wr]  <= i_col - COL_W'(1);
            q_last[r_wr] <= !i_emit.border;
        end
        if (push_b) begin
            q_pix[wr_b]  <= i_pixel;
            q_row[wr_b]  <= i_row;
            q_col[wr_b]  <= i_col;
            q_last[wr_b] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PW'(n_push);
            r_rd    <= r_rd + PW'(pop);
            r_count <= r_count + n_push - NW'(pop);
        end
    end

    assign o_res.valid       = (r_count != '0);
    assign o_res.pixel_out   = q_pix[r_rd];
    assign o_res.out_row     = q_row[r_rd];
    assign o_res.out_column  = q_col[r_rd];
    assign o_res.last_in_run = q_last[r_rd];
    assign o_count           = r_count;

endmodule

[rtl/unsharp_mask_3x3.sv]
// Top level of the streaming 3x3 unsharp mask.
//
// Pixels enter on i_pix in raster order, one request per 8-bit grey level,
// and are taken every cycle while the result queue has room. Results leave
// on o_res with their row and column; last_in_run marks the final result
// that a pixel produced. Border pixels are copied; each interior pixel is
// sharpened with a 1-2-1 binomial blur and appears when the pixel one row
// down and one column right is taken, interior result before border result.
// A result passes the stage 1, stage 2 and sharpen registers before it enters
// the queue and can leave at the next edge; the line store is one memory read
// at take and written back the next cycle.
// Throughput is one pixel per cycle, limited on the last row and the last
// column of a frame (two results per pixel) by the one-result-per-cycle output.
// When o_res is stalled the 16-entry queue fills; i_pix.ready drops while the
// queue lacks two free entries for each pixel in flight plus the next one, so
// nothing is lost. i_cfg writes width, height and gain, always ready, and
// may only be used while the block is empty.
// Reset (i_rst_n low, synchronous) clears counters, window and queue and
// loads a 640x480 frame with gain 1.0; line store contents are left as is.
module unsharp_mask_3x3 #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ums_pix_if.sink     i_pix,
    ums_res_if.source   o_res,
    ums_cfg_if.sink     i_cfg
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int RSV_W = ums_pkg::QCNT_W + 2;

    logic [WW-1:0]                       width;
    logic [HW-1:0]                       height;
    logic [ums_pkg::AMT_W-1:0]           amount;
    logic                                accept;

    logic                                s1_valid, s2_valid;
    logic [ums_pkg::PIX_W-1:0]           s2_centre, s2_pixel;
    logic signed [ums_pkg::DIFF_W-1:0]   s2_diff;
    ums_pkg::t_emit                      s2_emit;
    logic [ROW_W-1:0]                    s2_row;
    logic [COL_W-1:0]                    s2_col;

    logic                                s3_valid;
    logic [ums_pkg::PIX_W-1:0]           s3_sharp, s3_pixel;
    ums_pkg::t_emit                      s3_emit;
    logic [ROW_W-1:0]                    s3_row;
    logic [COL_W-1:0]                    s3_col;

    logic [ums_pkg::QCNT_W-1:0]          q_count;
    logic [RSV_W-1:0]                    reserve;

    // every pixel in flight may still need two queue entries
    assign reserve = RSV_W'(q_count) + RSV_W'({s1_valid, 1'b0}) + RSV_W'({s2_valid, 1'b0})
                   + RSV_W'({s3_valid, 1'b0}) + RSV_W'(2);
    assign i_pix.ready = (reserve <= RSV_W'(ums_pkg::QUEUE_DEPTH));
    assign accept      = i_pix.valid && i_pix.ready;

    ums_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_width  (width),
        .o_height (height),
        .o_amount (amount)
    );

    ums_line_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_pixel    (i_pix.pixel_in),
        .i_width    (width),
        .i_height   (height),
        .o_s1_valid (s1_valid),
        .o_valid    (s2_valid),
        .o_centre   (s2_centre),
        .o_diff     (s2_diff),
        .o_emit     (s2_emit),
        .o_pixel    (s2_pixel),
        .o_row      (s2_row),
        .o_col      (s2_col)
    );

    ums_sharpen #(
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    ) u_sharpen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s2_valid),
        .i_centre (s2_centre),
        .i_diff   (s2_diff),
        .i_emit   (s2_emit),
        .i_pixel  (s2_pixel),
        .i_row    (s2_row),
        .i_col    (s2_col),
        .i_amount (amount),
        .o_valid  (s3_valid),
        .o_sharp  (s3_sharp),
        .o_emit   (s3_emit),
        .o_pixel  (s3_pixel),
        .o_row    (s3_row),
        .o_col    (s3_col)
    );

    ums_out_queue #(
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .i_emit  (s3_emit),
        .i_sharp (s3_sharp),
        .i_pixel (s3_pixel),
        .i_row   (s3_row),
        .i_col   (s3_col),
        .o_count (q_count),
        .o_res   (o_res)
    );

endmodule

[bench/tb_unsharp_mask_3x3.sv]
// Self-checking testbench for the streaming 3x3 unsharp mask block.
module tb_unsharp_mask_3x3;

    localparam int PIX_W      = ums_pkg::PIX_W;
    localparam int IMG_W_W    = ums_pkg::IMG_W_W;
    localparam int IMG_H_W    = ums_pkg::IMG_H_W;
    localparam int AMT_W      = ums_pkg::AMT_W;
    localparam int CFG_IDX_W  = ums_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ums_pkg::CFG_DATA_W;
    localparam int FRAC_W     = ums_pkg::FRAC_W;
    localparam int ROUND_HALF = ums_pkg::ROUND_HALF;

    localparam int MAX_W         = 2048;
    localparam int MAX_H         = 4096;
    localparam int ROW_BITS      = 12;
    localparam int COL_BITS      = 11;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 1000;
    localparam int IDLE_PCT      = 37;
    localparam int PRELOAD_W     = 128;
    localparam int TILE_ITEMS    = 27;
    localparam int PRELOAD_ITEMS = 2 * PRELOAD_W + 1;
    localparam int TOTAL_ITEMS   = 1450;
    localparam int RANDOM_ITEMS  = TOTAL_ITEMS - TILE_ITEMS - PRELOAD_ITEMS;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0]    pixel;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] column;
        logic                last;
    } t_out_pixel;

    // Tracks the raster position, line stores and 3x3 window of the block and
    // queues the sharpened/copied pixels it must emit.
    class unsharp_predictor;
        logic [PIX_W-1:0]   upper_line [MAX_W];
        logic [PIX_W-1:0]   lower_line [MAX_W];
        logic [PIX_W-1:0]   win [6];
        int unsigned        row_pos;
        int unsigned        col_pos;
        logic [IMG_W_W-1:0] width_reg;
        logic [IMG_H_W-1:0] height_reg;
        logic [AMT_W-1:0]   amount_reg;
        t_out_pixel         expected_out [$];
        int                 mismatches;

        function new();
            foreach (upper_line[i]) begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            row_pos    = 0;
            col_pos    = 0;
            width_reg  = ums_pkg::WIDTH_RST;
            height_reg = ums_pkg::HEIGHT_RST;
            amount_reg = ums_pkg::AMOUNT_RST;
            mismatches = 0;
        endfunction

        function int unsigned bounded(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned frame_width();
            return bounded(width_reg, MAX_W);
        endfunction

        function int unsigned frame_height();
            return bounded(height_reg, MAX_H);
        endfunction

        function int pending();
            return expected_out.size();
        endfunction

        function void take_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                ums_pkg::CFG_IMAGE_WIDTH:    width_reg  = value[IMG_W_W-1:0];
                ums_pkg::CFG_IMAGE_HEIGHT:   height_reg = value[IMG_H_W-1:0];
                ums_pkg::CFG_SHARPEN_AMOUNT: amount_reg = value[AMT_W-1:0];
                default: ;
            endcase
        endfunction

        // c + amount/256*(c - blur/16) in 1/4096 units, round half up, clamp
        function logic [PIX_W-1:0] sharpened(int unsigned centre, int unsigned blur);
            longint v;
            v = 4096 * longint'(centre)
              + longint'(amount_reg) * (16 * longint'(centre) - longint'(blur))
              + ROUND_HALF;
            if (v < 0) return '0;
            v = v >>> FRAC_W;
            if (v > 255) return 8'd255;
            return v[PIX_W-1:0];
        endfunction

        function void take_pixel(logic [PIX_W-1:0] pix);
            int unsigned w, h, x, y, top, mid, blur;
            bit         inner, edge_px;
            t_out_pixel item;
            w = frame_width();
            h = frame_height();
            // a shrunk size wraps the position before the pixel is placed
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h) row_pos = 0;
            x = col_pos;
            y = row_pos;
            top = upper_line[x];
            mid = lower_line[x];
            inner   = (y >= 2) && (x >= 2);
            edge_px = (y == 0) || (y == h - 1) || (x == 0) || (x == w - 1);
            if (inner) begin
                blur = win[0] + 2 * win[3] + top
                     + 2 * win[1] + 4 * win[4] + 2 * mid
                     + win[2] + 2 * win[5] + pix;
                item.pixel  = sharpened(win[4], blur);
                item.row    = ROW_BITS'(y - 1);
                item.column = COL_BITS'(x - 1);
                item.last   = !edge_px;
                expected_out.push_back(item);
            end
            if (edge_px) begin
                item.pixel  = pix;
                item.row    = ROW_BITS'(y);
                item.column = COL_BITS'(x);
                item.last   = 1'b1;
                expected_out.push_back(item);
            end
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = PIX_W'(top);
            win[4] = PIX_W'(mid);
            win[5] = pix;
            upper_line[x] = PIX_W'(mid);
            lower_line[x] = pix;
            col_pos = x + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos = y + 1;
                if (row_pos >= h) row_pos = 0;
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_out_pixel got);
            t_out_pixel want;
            if (expected_out.size() == 0) begin
                $error("unexpected result: pixel_out %0d out_row %0d out_column %0d",
                       got.pixel, got.row, got.column);
                mismatches++;
                return;
            end
            want = expected_out.pop_front();
            compare_field("pixel_out",   want.pixel,  got.pixel);
            compare_field("out_row",     want.row,    got.row);
            compare_field("out_column",  want.column, got.column);
            compare_field("last_in_run", want.last,   got.last);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   steady = 1'b0;

    unsharp_predictor sharp_pred;

    ums_pix_if pix_ch ();
    ums_res_if #(.ROW_W(ROW_BITS), .COL_W(COL_BITS)) res_ch ();
    ums_cfg_if cfg_ch ();

    unsharp_mask_3x3 #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            sharp_pred.check_result({res_ch.pixel_out, res_ch.out_row,
                                     res_ch.out_column, res_ch.last_in_run});
        end
    end

    // ends the run once nothing has moved for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_unsharp_mask_3x3: FAIL");
        $finish;
    end

    // called and returns at a falling edge
    task automatic push_pixel(input logic [PIX_W-1:0] pix);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            pix_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.pixel_in <= pix;
        do @(posedge i_clk); while (!pix_ch.ready);
        sharp_pred.take_pixel(pix);
        @(negedge i_clk);
    endtask

    // block empty: all results out and the pipeline flushed
    task automatic drain();
        pix_ch.valid <= 1'b0;
        while (sharp_pred.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sharp_pred.take_config(idx, value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(int style, int base);
        case (style)
            0:       return PIX_W'($urandom_range(255));
            1:       return $urandom_range(1) ? 8'd255 : 8'd0;
            default: return PIX_W'(base - 8 + $urandom_range(16));
        endcase
    endfunction

    initial begin
        logic [PIX_W-1:0]      tiles [3][9];
        logic [CFG_DATA_W-1:0] tile_gain [3];
        logic [CFG_DATA_W-1:0] value;
        int unsigned           sent, w, h, area, cnt;
        int                    style, base;

        sharp_pred = new();
        i_rst_n         = 1'b0;
        pix_ch.valid    = 1'b0;
        pix_ch.pixel_in = '0;
        res_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = ums_pkg::CFG_IMAGE_WIDTH;
        cfg_ch.data     = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // 3x3 frames: one interior pixel each, emitted together with a border copy
        tiles[0] = '{0, 0, 0, 0, 255, 0, 0, 0, 0};               // saturates high
        tiles[1] = '{255, 255, 255, 255, 0, 255, 255, 255, 255}; // saturates low
        tiles[2] = '{1, 3, 1, 3, 1, 3, 1, 3, 1};                 // exactly half, rounds up
        tile_gain = '{13'd4095, 13'd4095, 13'd128};
        write_reg(ums_pkg::CFG_IMAGE_WIDTH, 13'd3);
        write_reg(ums_pkg::CFG_IMAGE_HEIGHT, 13'd3);
        for (int t = 0; t < 3; t++) begin
            drain();
            write_reg(ums_pkg::CFG_SHARPEN_AMOUNT, tile_gain[t]);
            for (int i = 0; i < 9; i++) push_pixel(tiles[t][i]);
        end

        // two full rows as wide as any later frame fill both line stores there,
        // so later size changes read only defined data
        drain();
        write_reg(ums_pkg::CFG_IMAGE_WIDTH, CFG_DATA_W'(PRELOAD_W));
        write_reg(ums_pkg::CFG_IMAGE_HEIGHT, 13'd2);
        steady = 1'b1;
        for (int i = 0; i < PRELOAD_ITEMS; i++) push_pixel(PIX_W'($urandom_range(255)));
        drain();
        steady = 1'b0;

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            drain();
            if ($urandom_range(3) != 0) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: value = CFG_DATA_W'($urandom_range(3, 12));
                    6:       value = CFG_DATA_W'($urandom_range(1, 2));
                    7:       value = CFG_DATA_W'($urandom_range(13, 48));
                    8:       value = $urandom_range(1) ? 13'h1000 : 13'h0000;
                    default: value = CFG_DATA_W'($urandom_range(49, PRELOAD_W));
                endcase
                write_reg(ums_pkg::CFG_IMAGE_WIDTH, value);
            end
            if ($urandom_range(3) != 0) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: value = CFG_DATA_W'($urandom_range(3, 8));
                    6:       value = CFG_DATA_W'($urandom_range(1, 2));
                    7:       value = CFG_DATA_W'($urandom_range(9, 20));
                    8:       value = 13'd0;
                    default: value = CFG_DATA_W'($urandom_range(21, 8191));
                endcase
                write_reg(ums_pkg::CFG_IMAGE_HEIGHT, value);
            end
            if ($urandom_range(3) != 0) begin
                case ($urandom_range(5))
                    0:       value = 13'd0;
                    1:       value = $urandom_range(1) ? 13'h1FFF : 13'h0FFF;
                    2:       value = 13'd256;
                    default: value = CFG_DATA_W'($urandom_range(8191));
                endcase
                write_reg(ums_pkg::CFG_SHARPEN_AMOUNT, value);
            end
            if ($urandom_range(7) == 0) write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom_range(8191)));

            w    = sharp_pred.frame_width();
            h    = sharp_pred.frame_height();
            area = w * h;
            // mostly whole frames; a partial count leaves the next size change mid-frame
            if (area <= 400 && $urandom_range(9) < 7)
                cnt = area * $urandom_range(1, 3);
            else
                cnt = $urandom_range(1, (area < 300) ? area : 300);
            if (cnt > RANDOM_ITEMS - sent) cnt = RANDOM_ITEMS - sent;
            style  = $urandom_range(2);
            base   = $urandom_range(8, 247);
            steady = ($urandom_range(5) == 0);
            for (int unsigned i = 0; i < cnt; i++) push_pixel(pick_pixel(style, base));
            sent += cnt;
        end

        drain();
        if (sharp_pred.mismatches == 0 && sharp_pred.pending() == 0)
            $display("tb_unsharp_mask_3x3: PASS");
        else
            $display("tb_unsharp_mask_3x3: FAIL");
        $finish;
    end

endmodule
